[rtl/cpt_pkg.sv]
package cpt_pkg;

    localparam int MAX_PARAMS  = 16;
    localparam int LINE_MAX    = 256;
    localparam int CNT_W       = $clog2(MAX_PARAMS);
    localparam int POS_W       = $clog2(LINE_MAX);
    localparam int FIFO_DEPTH  = 4;

    localparam logic [15:0] STR_MARK = 16'h7777;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [1:0] {
        PH_BETWEEN = 2'd0,
        PH_BUILD   = 2'd1,
        PH_TEXT    = 2'd2,
        PH_OWED    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PARAM  = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_UNTERM = 2'd2,
        KIND_MANY   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       hex_mode;
    } cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] param_value;
        logic [3:0]         param_count;
        logic               last;
    } result_t;

    // one character's worth of results, one or two of them
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } qentry_t;

endpackage

[rtl/cpt_front.sv]
module cpt_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cpt_pkg::cmd_t   cmd,
    input  logic            q_full,
    output logic            wr_en,
    output cpt_pkg::qentry_t wr_data
);

    cpt_pkg::phase_t              phase_reg, phase_next;
    logic [15:0]                  value_reg, value_next;
    logic                         neg_reg, neg_next;
    logic [cpt_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [cpt_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                         hex_reg, hex_next;
    logic                         fin_reg, fin_next;

    logic                         accept;
    logic [7:0]                   cu;
    logic                         is_dig;
    logic                         is_hexl;
    logic                         is_alpha;
    logic                         acc_ok;
    logic [15:0]                  acc_cur;
    logic [15:0]                  acc_zero;
    logic [cpt_pkg::POS_W-1:0]    off;

    function automatic logic [15:0] acc_val(input logic [15:0] v, input logic [7:0] c,
                                            input logic hex);
        logic [15:0] d;
        logic [15:0] r;
        d = 16'(c);
        if (c >= cpt_pkg::CH_0 && c <= cpt_pkg::CH_9)
        begin
            if (hex)
                r = (v << 4) + d - 16'(cpt_pkg::CH_0);
            else
                r = (v << 3) + (v << 1) + d - 16'(cpt_pkg::CH_0);
        end
        else if (hex && c >= cpt_pkg::CH_A && c <= cpt_pkg::CH_F)
        begin
            r = (v << 4) + d - 16'(cpt_pkg::CH_A) + 16'd10;
        end
        else
        begin
            r = ((v << 5) + v) ^ d;
        end
        return r;
    endfunction

    assign accept = push && !q_full;

    // classification of the character
    always_comb
    begin
        if (cmd.ch >= cpt_pkg::CH_LA && cmd.ch <= cpt_pkg::CH_LZ)
            cu = cmd.ch - cpt_pkg::CASE_GAP;
        else
            cu = cmd.ch;
        is_dig   = (cu >= cpt_pkg::CH_0) && (cu <= cpt_pkg::CH_9);
        is_hexl  = hex_reg && (cu >= cpt_pkg::CH_A) && (cu <= cpt_pkg::CH_F);
        is_alpha = ((cu >= cpt_pkg::CH_A) && (cu <= cpt_pkg::CH_Z)) || (cu == cpt_pkg::CH_USCORE);
        acc_ok   = is_dig || is_hexl || is_alpha;
        acc_cur  = acc_val(value_reg, cu, hex_reg);
        acc_zero = acc_val(16'h0000, cu, hex_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cpt_pkg::PH_BETWEEN;
            value_reg <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            hex_reg   <= 1'b0;
            fin_reg   <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            value_reg <= value_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            hex_reg   <= hex_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin
        cpt_pkg::result_t res [2];
        logic [1:0]       n;
        logic             btw;
        logic             txt;
        logic             had;
        logic [15:0]      v;

        phase_next = phase_reg;
        value_next = value_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        hex_next   = hex_reg;
        fin_next   = fin_reg;
        res[0]     = '0;
        res[1]     = '0;
        n          = 2'd0;
        btw        = 1'b0;
        txt        = 1'b0;
        had        = 1'b0;
        v          = '0;
        off        = '0;

        if (accept && cmd.first)
        begin
            phase_next = cpt_pkg::PH_BETWEEN;
            value_next = '0;
            neg_next   = 1'b0;
            cnt_next   = '0;
            pos_next   = '0;
            hex_next   = cmd.hex_mode;
            fin_next   = 1'b0;
        end
        else if (accept && !fin_reg)
        begin
            if (pos_reg != cpt_pkg::POS_W'(cpt_pkg::LINE_MAX - 1))
                pos_next = pos_reg + 1'b1;
            if (pos_next == cpt_pkg::POS_W'(cpt_pkg::LINE_MAX - 1))
                off = pos_next;
            else
                off = pos_next + 1'b1;

            unique case (phase_reg)
                cpt_pkg::PH_BUILD:
                begin
                    if (acc_ok)
                    begin
                        value_next = acc_cur;
                    end
                    else
                    begin
                        v = neg_reg ? (16'h0000 - value_reg) : value_reg;
                        if (cnt_next >= cpt_pkg::CNT_W'(cpt_pkg::MAX_PARAMS - 1))
                        begin
                            res[n[0]] = '{cpt_pkg::KIND_MANY, 16'sd0, 4'(cnt_next), 1'b0};
                            fin_next  = 1'b1;
                        end
                        else
                        begin
                            cnt_next  = cnt_next + 1'b1;
                            res[n[0]] = '{cpt_pkg::KIND_PARAM, v, 4'(cnt_next), 1'b0};
                        end
                        n = n + 2'd1;
                        if (!fin_next)
                        begin
                            phase_next = cpt_pkg::PH_BETWEEN;
                            btw        = 1'b1;
                        end
                    end
                end
                cpt_pkg::PH_TEXT:
                begin
                    txt = 1'b1;
                end
                cpt_pkg::PH_OWED:
                begin
                    if (cnt_next >= cpt_pkg::CNT_W'(cpt_pkg::MAX_PARAMS - 1))
                    begin
                        res[n[0]] = '{cpt_pkg::KIND_MANY, 16'sd0, 4'(cnt_next), 1'b0};
                        fin_next  = 1'b1;
                    end
                    else
                    begin
                        cnt_next  = cnt_next + 1'b1;
                        res[n[0]] = '{cpt_pkg::KIND_PARAM, 16'(pos_next), 4'(cnt_next), 1'b0};
                    end
                    n = n + 2'd1;
                    if (!fin_next)
                    begin
                        phase_next = cpt_pkg::PH_TEXT;
                        txt        = 1'b1;
                    end
                end
                default:
                begin
                    btw = 1'b1;
                end
            endcase

            if (btw)
            begin
                if (cmd.ch == cpt_pkg::CH_SPACE)
                begin
                    phase_next = cpt_pkg::PH_BETWEEN;
                end
                else if (cmd.ch == cpt_pkg::CH_NUL)
                begin
                    res[n[0]] = '{cpt_pkg::KIND_UNTERM, 16'sd0, 4'(cnt_next), 1'b0};
                    fin_next  = 1'b1;
                    n         = n + 2'd1;
                end
                else if (cmd.ch == cpt_pkg::CH_GT)
                begin
                    res[n[0]] = '{cpt_pkg::KIND_DONE, 16'sd0, 4'(cnt_next), 1'b0};
                    fin_next  = 1'b1;
                    n         = n + 2'd1;
                end
                else if (cmd.ch == cpt_pkg::CH_QUOTE)
                begin
                    had = (n != 2'd0);
                    if (cnt_next >= cpt_pkg::CNT_W'(cpt_pkg::MAX_PARAMS - 1))
                    begin
                        res[n[0]] = '{cpt_pkg::KIND_MANY, 16'sd0, 4'(cnt_next), 1'b0};
                        fin_next  = 1'b1;
                    end
                    else
                    begin
                        cnt_next  = cnt_next + 1'b1;
                        res[n[0]] = '{cpt_pkg::KIND_PARAM, cpt_pkg::STR_MARK, 4'(cnt_next),
                                      1'b0};
                    end
                    n = n + 2'd1;
                    if (!fin_next)
                    begin
                        if (had)
                        begin
                            phase_next = cpt_pkg::PH_OWED;
                        end
                        else
                        begin
                            if (cnt_next >= cpt_pkg::CNT_W'(cpt_pkg::MAX_PARAMS - 1))
                            begin
                                res[n[0]] = '{cpt_pkg::KIND_MANY, 16'sd0, 4'(cnt_next), 1'b0};
                                fin_next  = 1'b1;
                            end
                            else
                            begin
                                cnt_next  = cnt_next + 1'b1;
                                res[n[0]] = '{cpt_pkg::KIND_PARAM, 16'(off), 4'(cnt_next), 1'b0};
                            end
                            n          = n + 2'd1;
                            phase_next = cpt_pkg::PH_TEXT;
                        end
                    end
                end
                else
                begin
                    phase_next = cpt_pkg::PH_BUILD;
                    neg_next   = (cmd.ch == cpt_pkg::CH_MINUS);
                    value_next = '0;
                    if (cmd.ch != cpt_pkg::CH_MINUS)
                    begin
                        if (acc_ok)
                        begin
                            value_next = acc_zero;
                        end
                        else
                        begin
                            res[n[0]] = '{cpt_pkg::KIND_MANY, 16'sd0, 4'(cnt_next), 1'b0};
                            fin_next  = 1'b1;
                            n         = n + 2'd1;
                        end
                    end
                end
            end

            if (txt)
            begin
                if (cmd.ch == cpt_pkg::CH_NUL)
                begin
                    res[n[0]] = '{cpt_pkg::KIND_UNTERM, 16'sd0, 4'(cnt_next), 1'b0};
                    fin_next  = 1'b1;
                    n         = n + 2'd1;
                end
                else if (cmd.ch == cpt_pkg::CH_QUOTE)
                begin
                    phase_next = cpt_pkg::PH_BETWEEN;
                end
            end
        end

        if (n == 2'd1)
            res[0].last = 1'b1;
        if (n == 2'd2)
            res[1].last = 1'b1;

        wr_en      = (n != 2'd0);
        wr_data.two = n[1];
        wr_data.r0  = res[0];
        wr_data.r1  = res[1];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && wr_data.r0.kind == cpt_pkg::KIND_PARAM |-> wr_data.r0.param_count != 4'd0)
        else $error("parameter beat with a zero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg && !(accept && cmd.first) |-> !wr_en)
        else $error("result produced while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !wr_data.two && wr_data.r0.kind != cpt_pkg::KIND_PARAM |=> fin_reg)
        else $error("command end did not stop the tokenizer");

endmodule

[rtl/cpt_fifo.sv]
module cpt_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  cpt_pkg::qentry_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output cpt_pkg::qentry_t rd_data,
    output logic             q_empty
);

    localparam int PTR_W = $clog2(cpt_pkg::FIFO_DEPTH);

    cpt_pkg::qentry_t  mem_reg [cpt_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    cnt_reg, cnt_next;

    assign full    = (cnt_reg == (PTR_W+1)'(cpt_pkg::FIFO_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            if (wr_ptr_reg == PTR_W'(cpt_pkg::FIFO_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            if (rd_ptr_reg == PTR_W'(cpt_pkg::FIFO_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full) && !(rd_en && q_empty))
        else $error("queue overrun or underrun");

endmodule

[rtl/cpt_back.sv]
module cpt_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  cpt_pkg::qentry_t rd_data,
    output logic             rd_en,
    input  logic             pop,
    output logic             empty,
    output cpt_pkg::result_t result
);

    cpt_pkg::result_t out_reg, out_next;
    logic             vld_reg, vld_next;
    logic             sel_reg, sel_next;
    cpt_pkg::result_t cur;
    logic             take;

    assign cur   = sel_reg ? rd_data.r1 : rd_data.r0;
    assign take  = (!vld_reg || pop) && !q_empty;
    assign rd_en = take && cur.last;
    assign empty = !vld_reg;
    assign result = out_reg;

    always_comb
    begin
        out_next = out_reg;
        vld_next = vld_reg;
        sel_next = sel_reg;
        if (take)
        begin
            out_next = cur;
            vld_next = 1'b1;
            sel_next = !cur.last;
        end
        else if (pop)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            sel_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // second half of a pair waits at the head of the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> !q_empty && rd_data.two)
        else $error("second result selected with no pair at the head");

    assert property (@(posedge clk) disable iff (!rst_n)
        take && !cur.last |=> sel_reg && cur.last)
        else $error("pair split lost its second result");

endmodule

[rtl/command_parameter_tokenizer_core.sv]
// command parameter tokenizer
// cmd channel: one character per beat, push/full; a beat is taken when push is
//   high and full is low. first marks the opcode, which restarts the command
//   and samples hex_mode.
// result channel: empty/pop; the oldest result sits on result while empty is
//   low and leaves on a clock edge with pop high. a character gives zero, one
//   or two results, the last of them flagged by last.
// a taken character's results enter the queue, then the result register.
// throughput: one character per cycle while each gives at most one result and
//   full is low; the result register drains one result per cycle while pop is
//   high, so characters giving two results outrun it and fill the queue.
// a four-entry queue sits between the classifier and the result register; a
//   stalled receiver fills it and then full rises, with no beat lost.
// reset: queue and result register empty, tokenizer idle until an opcode.
module command_parameter_tokenizer_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  cpt_pkg::cmd_t    cmd,
    output logic             empty,
    input  logic             pop,
    output cpt_pkg::result_t result
);

    logic             wr_en;
    cpt_pkg::qentry_t wr_data;
    logic             rd_en;
    cpt_pkg::qentry_t rd_data;
    logic             q_empty;

    cpt_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd     (cmd),
        .q_full  (full),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    cpt_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .full    (full),
        .rd_en   (rd_en),
        .rd_data (rd_data),
        .q_empty (q_empty)
    );

    cpt_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .rd_data (rd_data),
        .rd_en   (rd_en),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
